/* rtl/core/ebp_pkg.sv */
// Shared constants, types and the square-root table for the embedding-bag pooling block.
package ebp_pkg;

	localparam int TableRows  = 1024;
	localparam int VectorDim  = 16;
	localparam int BagMax     = 256;
	localparam int RowW       = $clog2(TableRows);
	localparam int DimW       = $clog2(VectorDim);
	localparam int TabAddrW   = RowW + DimW;
	localparam int CntW       = $clog2(BagMax) + 1;
	localparam int AccW       = 48;
	localparam int EpochW     = 8;
	localparam int SqrtW      = 25;
	localparam int NumW       = 56;

	localparam logic [1:0] ModeSum  = 2'd0;
	localparam logic [1:0] ModeMean = 2'd1;

	localparam logic [1:0] RegMode   = 2'd0;
	localparam logic [1:0] RegWeight = 2'd1;
	localparam logic [1:0] RegDim    = 2'd2;

	typedef logic [SqrtW-1:0] sqrt_tab_t [0:BagMax-1];

	// floor(sqrt(n * 2^32)) for n = 1 .. BagMax, entry n-1
	function automatic sqrt_tab_t gen_sqrt_tab();
		sqrt_tab_t t;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		for (int i = 0; i < BagMax; i++) begin
			x = 64'(i + 1) << 32;
			r = '0;
			b = 64'd1 << 62;
			while (b > x) b = b >> 2;
			while (b != 0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			t[i] = SqrtW'(r);
		end
		return t;
	endfunction

	localparam sqrt_tab_t SqrtTab = gen_sqrt_tab();

endpackage

/* rtl/core/embedding_bag_pooling.sv */
// Embedding-bag pooling: table load, per-batch key dedup, weighted accumulation, combiners.
//
// Input stream s_*: one beat per item. s_tuser is the kind (0 table write, 1 bag entry),
// s_tlast marks the entry that closes its bag. A bag entry goes through the accept, a dedup
// read, 16 row reads through the single table memory port (one element per cycle) and the
// drain of the multiply and accumulate pipeline; the table read port sets the pace of the
// row walk, and no new item is taken until the entry is through.
// Output stream m_*: the unique index report of each entry comes first; on a bag end it is
// followed by dimension_in_use pooled elements, m_tlast on the final beat of each input.
// Sum skips the divider; mean and sqrtn pass each element through a bit-serial divider,
// except a sqrtn magnitude of 2^38 or more. The block holds results in one output register;
// when the receiver stalls, the block waits and accepts no new item until it can move on.
// Configuration writes through cfg_we / cfg_index / cfg_data, only while idle; users must
// ensure it, as the block does not. After reset each dedup entry is swept before the first
// item is taken; the same sweep runs after every 255th batch end, when the batch mark wraps.
module embedding_bag_pooling (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// table_row[9:0], table_col[13:10], table_value[45:14], key[55:46], weight[87:56],
	// last_in_batch[88], zero fill above
	input  logic [95:0] s_tdata,
	input  logic        s_tuser,   // kind
	input  logic        s_tlast,   // last_in_bag
	output logic        m_tvalid,
	input  logic        m_tready,
	// unique_index[9:0], is_new[10], element_index[14:11], pooled_value[46:15], saturated[47]
	output logic [47:0] m_tdata,
	output logic        m_tuser,   // result_kind
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int RW = ebp_pkg::RowW;
	localparam int DW = ebp_pkg::DimW;
	localparam int AW = ebp_pkg::AccW;
	localparam int EW = ebp_pkg::EpochW;
	localparam int NW = ebp_pkg::NumW;
	localparam int SW = ebp_pkg::SqrtW;
	localparam int CW = ebp_pkg::CntW;

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StLook  = 3'd1;
	localparam logic [2:0] StAcc   = 3'd2;
	localparam logic [2:0] StDrain = 3'd3;
	localparam logic [2:0] StPrep  = 3'd4;
	localparam logic [2:0] StDiv   = 3'd5;
	localparam logic [2:0] StOut   = 3'd6;
	localparam logic [2:0] StSweep = 3'd7;

	localparam logic signed [AW-1:0] AccMax = {1'b0, {(AW-1){1'b1}}};
	localparam logic signed [AW-1:0] AccMin = {1'b1, {(AW-1){1'b0}}};

	// Configuration registers
	logic [1:0] mode_q;
	logic       use_w_q;
	logic [4:0] dim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ebp_pkg::ModeSum;
			use_w_q <= 1'b1;
			dim_q   <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				ebp_pkg::RegMode:   mode_q  <= cfg_data[1:0];
				ebp_pkg::RegWeight: use_w_q <= cfg_data[0];
				ebp_pkg::RegDim:    dim_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack input beat
	logic [RW-1:0]      in_row;
	logic [DW-1:0]      in_col;
	logic [31:0]        in_val;
	logic [RW-1:0]      in_key;
	logic [31:0]        in_weight;
	logic               in_lbatch;
	assign in_row    = s_tdata[9:0];
	assign in_col    = s_tdata[13:10];
	assign in_val    = s_tdata[45:14];
	assign in_key    = s_tdata[55:46];
	assign in_weight = s_tdata[87:56];
	assign in_lbatch = s_tdata[88];

	logic [2:0] state_q;
	logic       accept;
	assign s_tready = (state_q == StIdle);
	assign accept   = s_tvalid && s_tready;

	// Memories
	logic [31:0]          tab_mem [0:(1 << ebp_pkg::TabAddrW)-1];
	logic [31:0]          tab_rdata;
	logic [EW+RW-1:0]     seen_mem [0:ebp_pkg::TableRows-1];
	logic [EW+RW-1:0]     seen_rdata;

	// Entry context
	logic [RW-1:0]        key_q;
	logic signed [31:0]   w_q;
	logic                 lbag_q;
	logic                 lbatch_q;
	logic [EW-1:0]        epoch_q;
	logic [10:0]          next_uq_q;
	logic                 sweep_req_q;
	logic [RW-1:0]        sweep_q;
	logic [CW-1:0]        bag_cnt_q;
	logic [DW:0]          rd_d_q;
	logic [DW-1:0]        e_d_q;
	logic [5:0]           div_cnt_q;

	// Report pending
	logic                 rpt_pend_q;
	logic [RW-1:0]        rpt_idx_q;
	logic                 rpt_new_q;
	logic                 rpt_last_q;

	// Accumulate pipeline
	logic                 valid_s1;
	logic [DW-1:0]        d_s1;
	logic                 valid_s2;
	logic [DW-1:0]        d_s2;
	logic signed [63:0]   prod_s2;
	logic signed [AW-1:0] acc_q [0:ebp_pkg::VectorDim-1];
	logic                 clip_q [0:ebp_pkg::VectorDim-1];

	// Divider and combiner
	logic [NW-1:0]        num_q;
	logic [SW:0]          rem_q;
	logic [SW-1:0]        div_q;
	logic                 neg_q;

	// Output register
	logic                 out_valid_q;
	logic [47:0]          out_data_q;
	logic                 out_user_q;
	logic                 out_last_q;
	logic                 out_free;
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	// Effective dimension: zero as one, clamp at the row width
	logic [DW-1:0] dim_last;
	always_comb begin
		if (dim_q == 5'd0)
			dim_last = '0;
		else if (dim_q > 5'(ebp_pkg::VectorDim))
			dim_last = DW'(ebp_pkg::VectorDim - 1);
		else
			dim_last = DW'(dim_q - 5'd1);
	end

	// Dedup lookup result
	logic          seen_hit;
	logic [RW-1:0] look_idx;
	assign seen_hit = (seen_rdata[EW+RW-1:RW] == epoch_q);
	assign look_idx = seen_hit ? seen_rdata[RW-1:0] : next_uq_q[RW-1:0];

	// Table memory: write on table beats, read during the row walk
	always_ff @(posedge clk) begin
		if (accept && !s_tuser)
			tab_mem[{in_row, in_col}] <= in_val;
		tab_rdata <= tab_mem[{key_q, rd_d_q[DW-1:0]}];
	end

	// Dedup memory: read on entry accept, write on first sight or sweep
	always_ff @(posedge clk) begin
		if (state_q == StSweep)
			seen_mem[sweep_q] <= '0;
		else if (state_q == StLook && !seen_hit)
			seen_mem[key_q] <= {epoch_q, next_uq_q[RW-1:0]};
		seen_rdata <= seen_mem[in_key];
	end

	// Round product to Q32.16 and add with saturation
	logic signed [63:0]   prod_rnd;
	logic signed [AW+1:0] acc_sum;
	assign prod_rnd = (prod_s2 + 64'sh8000) >>> 16;
	assign acc_sum  = {{2{acc_q[d_s2][AW-1]}}, acc_q[d_s2]}
	                + {{2{prod_rnd[AW-1]}}, prod_rnd[AW-1:0]};

	// Element read for the combiner
	logic signed [AW-1:0] acc_rd;
	logic [AW-1:0]        mag;
	assign acc_rd = acc_q[e_d_q];
	assign mag    = acc_rd[AW-1] ? AW'(-acc_rd) : AW'(acc_rd);

	logic [SW-1:0] sqrt_s;
	assign sqrt_s = ebp_pkg::SqrtTab[bag_cnt_q[CW-2:0] - (CW-1)'(1)];

	// Divider step
	logic [SW:0] rem_sh;
	assign rem_sh = {rem_q[SW-1:0], num_q[NW-1]};

	// Final clip to 32 bits
	logic        big;
	logic [31:0] res_val;
	always_comb begin
		big = neg_q ? (num_q > NW'(33'h080000000)) : (num_q > NW'(32'h7fffffff));
		if (big)
			res_val = neg_q ? 32'h80000000 : 32'h7fffffff;
		else
			res_val = neg_q ? -num_q[31:0] : num_q[31:0];
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(tab_rdata) * w_q;
		d_s2    <= d_s1;
	end

	// Control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StSweep;
			sweep_q     <= '0;
			epoch_q     <= EW'(1);
			sweep_req_q <= 1'b0;
			next_uq_q   <= '0;
			bag_cnt_q   <= '0;
			rpt_pend_q  <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			rd_d_q      <= '0;
			e_d_q       <= '0;
			div_cnt_q   <= '0;
			for (int i = 0; i < ebp_pkg::VectorDim; i++) begin
				acc_q[i]  <= '0;
				clip_q[i] <= 1'b0;
			end
		end else begin
			valid_s2 <= valid_s1;
			valid_s1 <= 1'b0;
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;

			// Accumulate stage
			if (valid_s2) begin
				if (acc_sum > $signed({{2{AccMax[AW-1]}}, AccMax})) begin
					acc_q[d_s2]  <= AccMax;
					clip_q[d_s2] <= 1'b1;
				end else if (acc_sum < $signed({{2{AccMin[AW-1]}}, AccMin})) begin
					acc_q[d_s2]  <= AccMin;
					clip_q[d_s2] <= 1'b1;
				end else begin
					acc_q[d_s2] <= acc_sum[AW-1:0];
				end
			end

			// Send the unique report
			if (rpt_pend_q && out_free) begin
				out_valid_q <= 1'b1;
				out_user_q  <= 1'b0;
				out_last_q  <= rpt_last_q;
				out_data_q  <= {37'd0, rpt_new_q, rpt_idx_q};
				rpt_pend_q  <= 1'b0;
			end

			case (state_q)
				StIdle: begin
					if (accept && s_tuser) begin
						key_q    <= in_key;
						w_q      <= use_w_q ? $signed(in_weight) : 32'sh00010000;
						lbag_q   <= s_tlast;
						lbatch_q <= in_lbatch;
						state_q  <= StLook;
					end
				end
				StLook: begin
					rpt_pend_q <= 1'b1;
					rpt_idx_q  <= look_idx;
					rpt_new_q  <= !seen_hit;
					rpt_last_q <= !lbag_q;
					if (lbatch_q) begin
						next_uq_q <= '0;
						epoch_q   <= epoch_q + EW'(1);
						if (epoch_q == {EW{1'b1}})
							sweep_req_q <= 1'b1;
					end else if (!seen_hit) begin
						next_uq_q <= next_uq_q + 11'd1;
					end
					if (bag_cnt_q < CW'(ebp_pkg::BagMax))
						bag_cnt_q <= bag_cnt_q + CW'(1);
					rd_d_q  <= '0;
					state_q <= StAcc;
				end
				StAcc: begin
					valid_s1 <= 1'b1;
					d_s1     <= rd_d_q[DW-1:0];
					rd_d_q   <= rd_d_q + (DW+1)'(1);
					if (rd_d_q == (DW+1)'(ebp_pkg::VectorDim - 1))
						state_q <= StDrain;
				end
				StDrain: begin
					if (!valid_s1 && !valid_s2 && !rpt_pend_q) begin
						e_d_q <= '0;
						if (lbag_q)
							state_q <= StPrep;
						else
							state_q <= sweep_req_q ? StSweep : StIdle;
					end
				end
				StPrep: begin
					neg_q     <= acc_rd[AW-1];
					rem_q     <= '0;
					div_cnt_q <= '0;
					if (mode_q == ebp_pkg::ModeSum) begin
						num_q   <= NW'(mag);
						state_q <= StOut;
					end else if (mode_q == ebp_pkg::ModeMean) begin
						num_q   <= NW'(mag) + NW'(bag_cnt_q >> 1);
						div_q   <= SW'(bag_cnt_q);
						state_q <= StDiv;
					end else if (mag >= (AW'(1) << 38)) begin
						num_q   <= NW'(1) << 40;
						state_q <= StOut;
					end else begin
						num_q   <= (NW'(mag) << 16) + NW'(sqrt_s >> 1);
						div_q   <= sqrt_s;
						state_q <= StDiv;
					end
				end
				StDiv: begin
					if (rem_sh >= {1'b0, div_q}) begin
						rem_q <= rem_sh - {1'b0, div_q};
						num_q <= {num_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						num_q <= {num_q[NW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'(NW - 1))
						state_q <= StOut;
				end
				StOut: begin
					if (out_free && !rpt_pend_q) begin
						out_valid_q <= 1'b1;
						out_user_q  <= 1'b1;
						out_last_q  <= (e_d_q == dim_last);
						out_data_q  <= {clip_q[e_d_q] | big, res_val, e_d_q, 11'd0};
						e_d_q       <= e_d_q + DW'(1);
						if (e_d_q == dim_last) begin
							for (int i = 0; i < ebp_pkg::VectorDim; i++) begin
								acc_q[i]  <= '0;
								clip_q[i] <= 1'b0;
							end
							bag_cnt_q <= '0;
							state_q   <= sweep_req_q ? StSweep : StIdle;
						end else begin
							state_q <= StPrep;
						end
					end
				end
				StSweep: begin
					sweep_q <= sweep_q + RW'(1);
					if (sweep_q == {RW{1'b1}}) begin
						epoch_q     <= EW'(1);
						sweep_req_q <= 1'b0;
						state_q     <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

/* sim/ebp_checker.sv */
// Checker for embedding_bag_pooling: predicts every output beat and compares it.
`timescale 1ns / 1ps

module ebp_checker
	import ebp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [95:0] s_tdata,
	input  logic        s_tuser,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic        kind;
		logic [9:0]  uidx;
		logic        is_new;
		logic [3:0]  eidx;
		logic [31:0] value;
		logic        sat;
		logic        last;
	} pool_beat_t;

	logic signed [31:0] emb_tab [0:TableRows*VectorDim-1];
	logic               key_seen [0:TableRows-1];
	logic [9:0]         key_uidx [0:TableRows-1];
	logic [10:0]        uniq_next;
	longint             acc [0:VectorDim-1];
	logic               acc_sat [0:VectorDim-1];
	int                 entries;
	logic [1:0]         mode_r;
	logic               weighted_r;
	logic [4:0]         dim_r;
	pool_beat_t         beats_due [$];

	function automatic longint root_q16(longint x);
		longint r;
		longint t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= x) r = t;
		end
		return r;
	endfunction

	// Fold one bag entry into the accumulators and queue the beats it causes.
	task automatic take_entry(input logic [95:0] d, input logic bag_end);
		logic [9:0]  key;
		logic        batch_end;
		longint      w;
		longint      s;
		longint      mag;
		longint      root;
		longint      r;
		longint      cnt;
		int          ndim;
		logic        neg;
		logic        sat;
		pool_beat_t  b;
		key = d[55:46];
		batch_end = d[88];
		b = '0;
		b.kind = 1'b0;
		if (key_seen[key]) begin
			b.uidx = key_uidx[key];
		end else begin
			b.uidx = uniq_next[9:0];
			b.is_new = 1'b1;
			key_seen[key] = 1'b1;
			key_uidx[key] = uniq_next[9:0];
			uniq_next = uniq_next + 11'd1;
		end
		w = weighted_r ? longint'($signed(d[87:56])) : 64'sh10000;
		for (int i = 0; i < VectorDim; i++) begin
			s = acc[i] + ((longint'(emb_tab[key*VectorDim+i]) * w + 32768) >>> 16);
			if (s > 64'sh7FFF_FFFF_FFFF) begin
				s = 64'sh7FFF_FFFF_FFFF;
				acc_sat[i] = 1'b1;
			end
			if (s < -64'sh8000_0000_0000) begin
				s = -64'sh8000_0000_0000;
				acc_sat[i] = 1'b1;
			end
			acc[i] = s;
		end
		if (entries < BagMax) entries++;
		if (batch_end) begin
			foreach (key_seen[k]) key_seen[k] = 1'b0;
			uniq_next = '0;
		end
		b.last = !bag_end;
		beats_due.push_back(b);
		if (!bag_end) return;

		// Pool: clamp the dimension, combine each element, clip to 32 bits
		ndim = (dim_r == 0) ? 1 : (dim_r > VectorDim) ? VectorDim : dim_r;
		cnt = (entries == 0) ? 1 : entries;
		root = root_q16(cnt << 32);
		for (int i = 0; i < ndim; i++) begin
			neg = acc[i] < 0;
			mag = neg ? -acc[i] : acc[i];
			sat = acc_sat[i];
			if (mode_r == ModeSum) begin
			end else if (mode_r == ModeMean) begin
				mag = (mag + cnt / 2) / cnt;
			end else if (mag >= (longint'(1) << 38)) begin
				mag = longint'(1) << 40;
			end else begin
				mag = ((mag << 16) + root / 2) / root;
			end
			r = neg ? -mag : mag;
			if (r > 64'sh7FFF_FFFF) begin
				r = 64'sh7FFF_FFFF;
				sat = 1'b1;
			end
			if (r < -64'sh8000_0000) begin
				r = -64'sh8000_0000;
				sat = 1'b1;
			end
			b = '0;
			b.kind = 1'b1;
			b.eidx = 4'(i);
			b.value = r[31:0];
			b.sat = sat;
			b.last = (i == ndim - 1);
			beats_due.push_back(b);
		end
		foreach (acc[i]) begin
			acc[i] = 0;
			acc_sat[i] = 1'b0;
		end
		entries = 0;
	endtask

	// Compare one output beat with the oldest expected beat
	task automatic check_beat();
		pool_beat_t e;
		if (beats_due.size() == 0) begin
			$error("unexpected output beat %h kind %0d", m_tdata, m_tuser);
			errors++;
			return;
		end
		e = beats_due.pop_front();
		if (m_tuser !== e.kind) begin
			$error("result_kind exp %0d got %0d", e.kind, m_tuser);
			errors++;
		end
		if (m_tdata[9:0] !== e.uidx) begin
			$error("unique_index exp %0d got %0d", e.uidx, m_tdata[9:0]);
			errors++;
		end
		if (m_tdata[10] !== e.is_new) begin
			$error("is_new exp %0d got %0d", e.is_new, m_tdata[10]);
			errors++;
		end
		if (m_tdata[14:11] !== e.eidx) begin
			$error("element_index exp %0d got %0d", e.eidx, m_tdata[14:11]);
			errors++;
		end
		if (m_tdata[46:15] !== e.value) begin
			$error("pooled_value exp %h got %h", e.value, m_tdata[46:15]);
			errors++;
		end
		if (m_tdata[47] !== e.sat) begin
			$error("saturated exp %0d got %0d", e.sat, m_tdata[47]);
			errors++;
		end
		if (m_tlast !== e.last) begin
			$error("last exp %0d got %0d", e.last, m_tlast);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		foreach (emb_tab[i]) emb_tab[i] = '0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (key_seen[k]) key_seen[k] = 1'b0;
			foreach (acc[i]) begin
				acc[i] = 0;
				acc_sat[i] = 1'b0;
			end
			uniq_next = '0;
			entries = 0;
			mode_r = ModeSum;
			weighted_r = 1'b1;
			dim_r = 5'd16;
			beats_due.delete();
		end else begin
			if (m_tvalid && m_tready) check_beat();
			if (cfg_we) begin
				case (cfg_index)
					RegMode:   mode_r = cfg_data[1:0];
					RegWeight: weighted_r = cfg_data[0];
					RegDim:    dim_r = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (!s_tuser) begin
					emb_tab[{s_tdata[9:0], s_tdata[13:10]}] = $signed(s_tdata[45:14]);
				end else begin
					take_entry(s_tdata, s_tlast);
				end
			end
		end
		pending <= beats_due.size();
	end

endmodule

/* sim/tb_top.sv */
// Testbench top for embedding_bag_pooling: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
	import ebp_pkg::*;

	localparam int CycleLimit = 3000000;
	localparam logic TabWrite = 1'b0;
	localparam logic BagEntry = 1'b1;
	localparam logic [1:0] ModeSqrtn = 2'd2;
	localparam logic [1:0] ModeSqrtnAlt = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [4:0]  cfg_data = '0;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          idle_pct = 28;
	logic        hold_req = 1'b0;
	logic [9:0]  rows_loaded [0:11];

	embedding_bag_pooling dut (.*);

	ebp_checker chk (.*);

	always #10 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Drive output backpressure; hold off for a long stretch once when asked
	initial begin : sink
		int hold;
		logic held;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				hold = 4000;
				held = 1'b1;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	function automatic logic [31:0] pick_q16();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1, 2: return $urandom;
			default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
		endcase
	endfunction

	// Offer one beat with random gaps ahead of it and wait for acceptance
	task automatic send(input logic kind, input logic [95:0] d, input logic bag_end);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= d;
		s_tlast <= bag_end;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_elem(input logic [9:0] row, input logic [3:0] col,
				input logic [31:0] v);
		send(TabWrite, {50'b0, v, col, row}, 1'b0);
	endtask

	task automatic bag_entry(input logic [9:0] key, input logic [31:0] w,
				input logic bag_end, input logic batch_end);
		send(BagEntry, {7'b0, batch_end, w, key, 46'b0}, bag_end);
	endtask

	// Drain and wait out the pipeline, then load all three registers
	task automatic set_regs(input logic [1:0] mode, input logic wsel, input logic [4:0] dim);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= RegMode;
		cfg_data <= {3'b0, mode};
		@(posedge clk);
		cfg_index <= RegWeight;
		cfg_data <= {4'b0, wsel};
		@(posedge clk);
		cfg_index <= RegDim;
		cfg_data <= dim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_bags(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 5);
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 4) == 0) begin
					write_elem(rows_loaded[$urandom_range(0, 11)], 4'($urandom),
						pick_q16());
					sent++;
				end
				bag_entry(rows_loaded[$urandom_range(0, 11)], pick_q16(), j == len - 1,
					$urandom_range(0, 6) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load the rows that bag keys may use; extremes in the edge rows
		rows_loaded[0] = 10'd0;
		rows_loaded[1] = 10'd1023;
		for (int r = 2; r < 12; r++) rows_loaded[r] = 10'($urandom);
		idle_pct = 0;
		for (int r = 0; r < 12; r++)
			for (int c = 0; c < VectorDim; c++)
				write_elem(rows_loaded[r], 4'(c),
					(r == 0) ? 32'h7FFF_FFFF : (r == 1) ? 32'h8000_0000 : pick_q16());
		idle_pct = 28;

		// Directed: weight extremes, repeated keys, batch end inside a bag
		bag_entry(10'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
		bag_entry(10'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
		bag_entry(10'd1023, 32'h8000_0000, 1'b1, 1'b0);
		bag_entry(10'd1023, 32'h7FFF_FFFF, 1'b0, 1'b1);
		bag_entry(10'd1023, 32'h0, 1'b1, 1'b0);
		bag_entry(rows_loaded[2], 32'h0001_0000, 1'b1, 1'b1);
		bag_entry(rows_loaded[3], 32'hFFFF_0000, 1'b0, 1'b0);
		bag_entry(rows_loaded[3], 32'h0000_8000, 1'b1, 1'b1);
		write_elem(10'd1023, 4'd15, 32'h1234_5678);
		bag_entry(10'd1023, 32'h0000_0001, 1'b1, 1'b0);

		set_regs(ModeMean, 1'b0, 5'd0);
		bag_entry(10'd0, 32'h0, 1'b0, 1'b0);
		bag_entry(rows_loaded[4], 32'h0, 1'b1, 1'b1);
		random_bags(15);

		set_regs(ModeSqrtn, 1'b1, 5'd7);
		bag_entry(10'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
		random_bags(15);

		// Stretch with no gaps on either side, then stall the receiver
		set_regs(ModeSum, 1'b1, 5'd16);
		idle_pct = 0;
		random_bags(15);
		idle_pct = 28;
		hold_req <= 1'b1;
		random_bags(15);
		hold_req <= 1'b0;

		set_regs(ModeSqrtnAlt, 1'b0, 5'd31);
		random_bags(15);

		set_regs(ModeMean, 1'b1, 5'd1);
		random_bags(15);

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
